@@ hdl/bwr_pkg.sv @@
// bwr_pkg: types, constants and the arctangent table of the beacon width ranging block
// used by every module in hdl; depends on nothing
package bwr_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int COORD_BITS   = 16;
	localparam int FRAC_BITS    = 10;
	localparam int CORDIC_STEPS = 30;
	localparam int X_BITS       = 33;
	localparam int Z_BITS       = 34;
	localparam int QUOT_BITS    = 15;
	localparam int LANES        = 3;

	// lane roles inside each rotation cell
	localparam int LANE_HALF = 0;
	localparam int LANE_HEAD = 1;
	localparam int LANE_BEAR = 2;

	localparam logic signed [X_BITS-1:0] CORDIC_GAIN = X_BITS'(652032874);

	// configuration register indexes
	localparam logic [1:0] REG_TOWER_RADIUS  = 2'd0;
	localparam logic [1:0] REG_SENSOR_OFFSET = 2'd1;
	localparam logic [1:0] REG_MAX_RANGE     = 2'd2;

	typedef struct packed {
		logic [ANGLE_BITS-1:0]        rise_angle;
		logic [ANGLE_BITS-1:0]        fall_angle;
		logic signed [COORD_BITS-1:0] robot_x;
		logic signed [COORD_BITS-1:0] robot_y;
		logic [ANGLE_BITS-1:0]        robot_heading;
	} bwr_in_t;

	typedef struct packed {
		logic                         found;
		logic signed [COORD_BITS-1:0] target_x;
		logic signed [COORD_BITS-1:0] target_y;
	} bwr_out_t;

	typedef struct packed {
		logic                     flip;
		logic signed [X_BITS-1:0] x;
		logic signed [X_BITS-1:0] y;
		logic signed [Z_BITS-1:0] z;
	} bwr_rot_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] rx;
		logic signed [COORD_BITS-1:0] ry;
	} bwr_side_t;

	typedef struct packed {
		logic                         nf;
		logic [31:0]                  s;
		logic signed [X_BITS-1:0]     sh;
		logic signed [X_BITS-1:0]     ch;
		logic signed [X_BITS-1:0]     sb;
		logic signed [X_BITS-1:0]     cb;
		logic signed [COORD_BITS-1:0] rx;
		logic signed [COORD_BITS-1:0] ry;
	} bwr_dside_t;

	typedef struct packed {
		logic [31:0]          p;
		logic [QUOT_BITS-1:0] q;
	} bwr_div_t;

	// arctangent of 2^-i in 32-bit binary angle
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/bwr_cordic_cell.sv @@
// bwr_cordic_cell: one registered rotation step for three angle lanes
// depends on bwr_pkg
module bwr_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_i,
	input  bwr_pkg::bwr_rot_t [bwr_pkg::LANES-1:0] rot_i,
	input  bwr_pkg::bwr_side_t                  side_i,
	output logic                                vld_o,
	output bwr_pkg::bwr_rot_t [bwr_pkg::LANES-1:0] rot_o,
	output bwr_pkg::bwr_side_t                  side_o
);
	import bwr_pkg::*;

	localparam logic signed [Z_BITS-1:0] ATAN = $signed({{(Z_BITS-32){1'b0}}, atan_turn(STEP)});

	bwr_rot_t [LANES-1:0] nxt;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			nxt[l].flip = rot_i[l].flip;
			if (!rot_i[l].z[Z_BITS-1]) begin
				nxt[l].x = rot_i[l].x - (rot_i[l].y >>> STEP);
				nxt[l].y = rot_i[l].y + (rot_i[l].x >>> STEP);
				nxt[l].z = rot_i[l].z - ATAN;
			end else begin
				nxt[l].x = rot_i[l].x + (rot_i[l].y >>> STEP);
				nxt[l].y = rot_i[l].y - (rot_i[l].x >>> STEP);
				nxt[l].z = rot_i[l].z + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_o  <= nxt;
			side_o <= side_i;
		end
	end

endmodule

@@ hdl/bwr_div_cell.sv @@
// bwr_div_cell: one registered restoring division step, one quotient bit
// depends on bwr_pkg
module bwr_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_i,
	input  bwr_pkg::bwr_div_t   div_i,
	input  bwr_pkg::bwr_dside_t side_i,
	output logic                vld_o,
	output bwr_pkg::bwr_div_t   div_o,
	output bwr_pkg::bwr_dside_t side_o
);
	import bwr_pkg::*;

	logic [31:0] p2;
	logic        ge;
	bwr_div_t    nxt;

	always_comb begin
		p2    = {div_i.p[30:0], 1'b0};
		ge    = (p2 >= side_i.s);
		nxt.p = ge ? (p2 - side_i.s) : p2;
		nxt.q = {div_i.q[QUOT_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_o  <= nxt;
			side_o <= side_i;
		end
	end

endmodule

@@ hdl/beacon_width_ranging.sv @@
// beacon_width_ranging: top level, opponent position from beacon edge bearings
// depends on bwr_pkg, bwr_cordic_cell and bwr_div_cell
//
// One result per input item, one item accepted per clock while the output side
// takes results. The datapath is a chain of 30 rotation cells (sine and cosine of
// the half width, the heading and heading plus bearing, three lanes per cell),
// one setup register, 15 division cells that give one range bit each, one
// multiply register and the output register. The whole chain advances together
// whenever the output register is empty or its result is transferred in that cycle,
// so in_ready follows out_ready once a result waits. Configuration writes are always
// taken (cfg_ready is high) and must only be made while no item is in flight. A range
// that does not fit 15 bits, or exceeds max_range, or a zero sine, gives found 0 and
// zero coordinates; coordinates saturate to the signed output range.
module beacon_width_ranging (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bwr_pkg::bwr_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bwr_pkg::bwr_out_t out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [14:0]      cfg_data
);
	import bwr_pkg::*;

	localparam int PW        = 50;
	localparam int TERM_BITS = 20;
	localparam int SUM_BITS  = COORD_BITS + 10;
	localparam logic signed [SUM_BITS-1:0] SAT_HI =
		$signed({{(SUM_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
	localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

	// configuration registers
	logic [11:0]        tower_radius_q;
	logic signed [12:0] sensor_offset_q;
	logic [14:0]        max_range_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tower_radius_q  <= 12'd41;
			sensor_offset_q <= 13'sd0;
			max_range_q     <= 15'(4 << FRAC_BITS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOWER_RADIUS:  tower_radius_q  <= cfg_data[11:0];
				REG_SENSOR_OFFSET: sensor_offset_q <= cfg_data[12:0];
				REG_MAX_RANGE:     max_range_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole chain moves when the output register can take a result
	logic en;
	logic out_valid_q;
	bwr_out_t out_data_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// angle setup: fold into the right half plane, remember the flip
	function automatic bwr_rot_t prep(input logic [31:0] a);
		bwr_rot_t r;
		logic [31:0] t;
		r.flip = a[31] ^ a[30];
		t      = {a[31] ^ r.flip, a[30:0]};
		r.x    = CORDIC_GAIN;
		r.y    = '0;
		r.z    = Z_BITS'($signed(t));
		return r;
	endfunction

	logic [31:0] rise_w, fall_w, head_w, half_w, bear_w;
	bwr_rot_t [LANES-1:0] rot_in;
	bwr_side_t side_in;

	always_comb begin
		rise_w = {in_data.rise_angle, {(32-ANGLE_BITS){1'b0}}};
		fall_w = {in_data.fall_angle, {(32-ANGLE_BITS){1'b0}}};
		head_w = {in_data.robot_heading, {(32-ANGLE_BITS){1'b0}}};
		half_w = (fall_w - rise_w) >> 1;
		bear_w = rise_w + half_w;
		rot_in[LANE_HALF] = prep(half_w);
		rot_in[LANE_HEAD] = prep(head_w);
		rot_in[LANE_BEAR] = prep(head_w + bear_w);
		side_in.rx = in_data.robot_x;
		side_in.ry = in_data.robot_y;
	end

	// rotation chain
	logic                 c_vld  [0:CORDIC_STEPS];
	bwr_rot_t [LANES-1:0] c_rot  [0:CORDIC_STEPS];
	bwr_side_t            c_side [0:CORDIC_STEPS];

	assign c_vld[0]  = in_valid;
	assign c_rot[0]  = rot_in;
	assign c_side[0] = side_in;

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		bwr_cordic_cell #(.STEP(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (c_vld[g]),
			.rot_i  (c_rot[g]),
			.side_i (c_side[g]),
			.vld_o  (c_vld[g+1]),
			.rot_o  (c_rot[g+1]),
			.side_o (c_side[g+1])
		);
	end

	// division setup: |sine of half width|, undo the flip on the other lanes
	bwr_rot_t [LANES-1:0] rl;
	bwr_dside_t dside_w;
	bwr_div_t   div_w;
	logic signed [X_BITS-1:0] y_neg;

	always_comb begin
		rl         = c_rot[CORDIC_STEPS];
		y_neg      = -rl[LANE_HALF].y;
		dside_w.s  = rl[LANE_HALF].y[X_BITS-1] ? y_neg[31:0] : rl[LANE_HALF].y[31:0];
		dside_w.sh = rl[LANE_HEAD].flip ? -rl[LANE_HEAD].y : rl[LANE_HEAD].y;
		dside_w.ch = rl[LANE_HEAD].flip ? -rl[LANE_HEAD].x : rl[LANE_HEAD].x;
		dside_w.sb = rl[LANE_BEAR].flip ? -rl[LANE_BEAR].y : rl[LANE_BEAR].y;
		dside_w.cb = rl[LANE_BEAR].flip ? -rl[LANE_BEAR].x : rl[LANE_BEAR].x;
		dside_w.rx = c_side[CORDIC_STEPS].rx;
		dside_w.ry = c_side[CORDIC_STEPS].ry;
		div_w.p    = {5'b0, tower_radius_q, 15'b0};
		div_w.q    = '0;
		// quotient of 2^15 or more is over any limit
		dside_w.nf = (dside_w.s == 32'd0) || (div_w.p >= dside_w.s);
	end

	logic d_vld [0:QUOT_BITS];
	bwr_div_t   d_div  [0:QUOT_BITS];
	bwr_dside_t d_side [0:QUOT_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_vld[0] <= 1'b0;
		end else if (en) begin
			d_vld[0] <= c_vld[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_div[0]  <= div_w;
			d_side[0] <= dside_w;
		end
	end

	for (genvar g = 0; g < QUOT_BITS; g++) begin : g_div
		bwr_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (d_vld[g]),
			.div_i  (d_div[g]),
			.side_i (d_side[g]),
			.vld_o  (d_vld[g+1]),
			.div_o  (d_div[g+1]),
			.side_o (d_side[g+1])
		);
	end

	// Q30 products, rounded half up
	function automatic logic signed [TERM_BITS-1:0] mul_round(
		input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b
	);
		logic signed [PW-1:0] prod;
		logic signed [PW-1:0] r;
		prod = a * b;
		r    = (prod + (PW'(1) <<< 30 >>> 1)) >>> 30;
		return r[TERM_BITS-1:0];
	endfunction

	bwr_dside_t ds;
	logic [QUOT_BITS-1:0] range_w;
	logic signed [PW-1:0] off_w, rng_w;

	logic                         m_vld_s1;
	logic                         found_s1;
	logic signed [TERM_BITS-1:0]  ox_s1, oy_s1, tx_s1, ty_s1;
	logic signed [COORD_BITS-1:0] rx_s1, ry_s1;

	always_comb begin
		ds      = d_side[QUOT_BITS];
		range_w = d_div[QUOT_BITS].q;
		off_w   = PW'(sensor_offset_q);
		rng_w   = PW'($signed({1'b0, range_w}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_s1 <= 1'b0;
		end else if (en) begin
			m_vld_s1 <= d_vld[QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_s1 <= !ds.nf && (range_w <= max_range_q);
			ox_s1    <= mul_round(off_w, PW'(ds.ch));
			oy_s1    <= mul_round(off_w, PW'(ds.sh));
			tx_s1    <= mul_round(rng_w, PW'(ds.cb));
			ty_s1    <= mul_round(rng_w, PW'(ds.sb));
			rx_s1    <= ds.rx;
			ry_s1    <= ds.ry;
		end
	end

	// final sum and saturation
	logic signed [SUM_BITS-1:0] sx, sy;
	logic signed [COORD_BITS-1:0] qx, qy;

	always_comb begin
		sx = SUM_BITS'(rx_s1) + SUM_BITS'(ox_s1) + SUM_BITS'(tx_s1);
		sy = SUM_BITS'(ry_s1) + SUM_BITS'(oy_s1) + SUM_BITS'(ty_s1);
		if (sx > SAT_HI)      qx = SAT_HI[COORD_BITS-1:0];
		else if (sx < SAT_LO) qx = SAT_LO[COORD_BITS-1:0];
		else                  qx = sx[COORD_BITS-1:0];
		if (sy > SAT_HI)      qy = SAT_HI[COORD_BITS-1:0];
		else if (sy < SAT_LO) qy = SAT_LO[COORD_BITS-1:0];
		else                  qy = sy[COORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= m_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.found    <= found_s1;
			out_data_q.target_x <= found_s1 ? qx : '0;
			out_data_q.target_y <= found_s1 ? qy : '0;
		end
	end

endmodule

@@ test/tb_beacon_width_ranging.sv @@
// tb_beacon_width_ranging: self-checking testbench of the beacon width ranging block
// depends on bwr_pkg and beacon_width_ranging; a cordic-based predictor checks every result
module tb_beacon_width_ranging;
	import bwr_pkg::*;

	localparam int LATENCY     = 48;
	localparam int CYCLE_LIMIT = 400000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	bwr_in_t   in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	bwr_out_t  out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_data = '0;

	// predictor copy of the registers
	logic [11:0]        radius_q;
	logic signed [12:0] offset_q;
	logic [14:0]        max_range_q;

	bwr_out_t expected_fixes[$];
	int       error_count = 0;
	int       cycle_count = 0;
	bit       rx_idle_on = 1'b1;
	bit       tx_idle_on = 1'b1;

	beacon_width_ranging u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// rotation-mode cordic, sine and cosine in q30 of a 32-bit binary angle
	task automatic cordic_sin_cos(input logic [31:0] ang, output longint sn, output longint cs);
		longint x, y, z, dx, dy;
		logic [31:0] t;
		bit flip;
		x = 652032874;
		y = 0;
		t = ang;
		flip = 0;
		if (t >= 32'h40000000 && t < 32'hC0000000) begin
			t = t + 32'h80000000;
			flip = 1;
		end
		z = longint'($signed(t));
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(i));
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		sn = y;
		cs = x;
	endtask

	function automatic longint scale_q30(longint len, longint trig);
		return (len * trig + (longint'(1) << 29)) >>> 30;
	endfunction

	function automatic logic signed [15:0] clamp_coord(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return v[15:0];
	endfunction

	// expected fix for one set of beacon edges
	task automatic predict_fix(input bwr_in_t it, output bwr_out_t fix);
		logic [31:0] rise, fall, head, width, half, bearing;
		longint s_half, c_half, sh, ch, sb, cb, range, off;
		rise = {it.rise_angle, 16'h0};
		fall = {it.fall_angle, 16'h0};
		head = {it.robot_heading, 16'h0};
		width = fall - rise;
		half = width >> 1;
		bearing = rise + half;
		fix = '0;
		cordic_sin_cos(half, s_half, c_half);
		if (s_half < 0) s_half = -s_half;
		if (s_half <= 0) return;
		range = (longint'(radius_q) << 30) / s_half;
		if (range > longint'(max_range_q)) return;
		off = longint'(offset_q);
		cordic_sin_cos(head, sh, ch);
		cordic_sin_cos(head + bearing, sb, cb);
		fix.found = 1'b1;
		fix.target_x = clamp_coord(longint'(it.robot_x) + scale_q30(off, ch) + scale_q30(range, cb));
		fix.target_y = clamp_coord(longint'(it.robot_y) + scale_q30(off, sh) + scale_q30(range, sb));
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// result side: random stall bursts, compare each transfer
	initial begin
		int burst;
		forever begin
			@(posedge clk);
			if (rx_idle_on && burst == 0 && $urandom_range(0, 5) == 0)
				burst = $urandom_range(1, 8);
			if (burst > 0) begin
				out_ready <= 1'b0;
				burst--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		bwr_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_fixes.size() == 0) begin
				report_mismatch("unexpected result", out_data.found, 0);
			end else begin
				want = expected_fixes.pop_front();
				if (out_data.found !== want.found)
					report_mismatch("found", out_data.found, want.found);
				if (out_data.target_x !== want.target_x)
					report_mismatch("target_x", out_data.target_x, want.target_x);
				if (out_data.target_y !== want.target_y)
					report_mismatch("target_y", out_data.target_y, want.target_y);
			end
		end
	end

	// one input transfer, with an optional idle burst first
	task automatic send_edges(input bwr_in_t it);
		bwr_out_t fix;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		predict_fix(it, fix);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		expected_fixes.push_back(fix);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_fixes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TOWER_RADIUS:  radius_q = val[11:0];
			REG_SENSOR_OFFSET: offset_q = val[12:0];
			REG_MAX_RANGE:     max_range_q = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [11:0] rad, input logic signed [12:0] off,
			input logic [14:0] lim);
		write_reg(REG_TOWER_RADIUS, {3'b0, rad});
		write_reg(REG_SENSOR_OFFSET, {2'b0, off});
		write_reg(REG_MAX_RANGE, lim);
	endtask

	function automatic bwr_in_t random_edges(bit near);
		bwr_in_t it;
		it.rise_angle = 16'($urandom);
		// narrow widths when near is set
		it.fall_angle = near ? it.rise_angle + 16'($urandom_range(1, 20000)) : 16'($urandom);
		it.robot_x = $signed(16'($urandom));
		it.robot_y = $signed(16'($urandom));
		it.robot_heading = 16'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			it.robot_x = $signed(16'($urandom_range(0, 4096)));
			it.robot_y = $signed(16'($urandom_range(0, 4096)));
		end
		return it;
	endfunction

	function automatic bwr_in_t mk(logic [15:0] r, logic [15:0] f, logic [15:0] x,
			logic [15:0] y, logic [15:0] h);
		bwr_in_t it;
		it.rise_angle = r; it.fall_angle = f;
		it.robot_x = x; it.robot_y = y; it.robot_heading = h;
		return it;
	endfunction

	task automatic test_edge_cases();
		send_edges(mk(16'h1000, 16'h1000, 16'h0100, 16'h0100, 16'h0000)); // equal edges
		send_edges(mk(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
		send_edges(mk(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h4000)); // wrap
		send_edges(mk(16'h0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000)); // half turn
		send_edges(mk(16'hF000, 16'h1000, 16'h7FFF, 16'h7FFF, 16'h0000)); // saturate high
		send_edges(mk(16'h7000, 16'h9000, 16'h8000, 16'h8000, 16'h0000)); // saturate low
		send_edges(mk(16'h0010, 16'h0011, 16'h0000, 16'h0000, 16'hC000)); // range over limit
		send_edges(mk(16'h2000, 16'h4000, 16'hFFFF, 16'h0001, 16'h2000));
		drain_pipeline();
	endtask

	task automatic test_zero_radius();
		configure(12'd0, 13'sd4095, 15'd0);
		send_edges(mk(16'h1000, 16'h2000, 16'h0400, 16'hFC00, 16'h6000));
		send_edges(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_edges(mk(16'hABCD, 16'hABD0, 16'h7F00, 16'h7F00, 16'h0000));
		drain_pipeline();
	endtask

	task automatic test_extreme_config();
		configure(12'd4095, -13'sd4096, 15'd32767);
		repeat (8) send_edges(random_edges(1));
		send_edges(mk(16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
		drain_pipeline();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 400 == 0) begin
				drain_pipeline();
				configure(12'($urandom_range(0, 4095)), $signed(13'($urandom)),
					15'($urandom_range(0, 32767)));
			end
			send_edges(random_edges($urandom_range(0, 4) != 0));
		end
		drain_pipeline();
	endtask

	initial begin
		radius_q = 12'd41;
		offset_q = '0;
		max_range_q = 15'd4096;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_cases();
		test_zero_radius();
		test_extreme_config();
		test_random(1700);
		// no idling in the last stretch
		configure(12'd41, 13'sd100, 15'd8192);
		tx_idle_on = 0;
		rx_idle_on = 0;
		test_random(300);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0 && expected_fixes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/bwr_pkg.sv
hdl/bwr_cordic_cell.sv
hdl/bwr_div_cell.sv
hdl/beacon_width_ranging.sv
test/tb_beacon_width_ranging.sv
